// ===== rtl/icl_pkg.sv =====
// Shared constants and types for the interval cursor lookup block.
`default_nettype none
package icl_pkg;

    // Table geometry and time width
    localparam int MAX_ENTRIES = 1024;
    localparam int IDX_W       = 10;
    localparam int TIME_W      = 48;
    localparam int CNT_W       = 11;
    localparam int CUR_W       = IDX_W + 2;

    // Stream and register port widths
    localparam int IN_DATA_W   = 160;
    localparam int OUT_DATA_W  = 16;
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;

    // Register map, as word index taken from paddr
    localparam logic REG_ENTRY_COUNT = 1'b0;

    // Command codes carried in the input tuser bit
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // Comparator outcome of stored time against query time
    typedef struct packed {
        logic gt;
        logic lt;
    } t_cmp_res;

endpackage
`default_nettype wire

// ===== rtl/interval_cursor_lookup.sv =====
// Top level: interval table, cursor sequencer, register port and stream ports.
// A load word is written into the table as it is taken. A query clamps the cursor,
// walks it back and then forward over the entries, checks where it stops and
// registers a result word; a walk off either end or an empty table gives a miss.
// The next word is taken once the result registers, later while an old one is held.
// Reset clears cursor, entry count and handshake state; the table is left unloaded.
`default_nettype none
module interval_cursor_lookup (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // Input stream
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    // tdata: entry_index[9:0], begin_time[57:10], end_time[105:58],
    //        query_time[153:106], zero pad
    input  wire logic [icl_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // tuser: cmd
    input  wire logic                             s_axis_tuser,
    // Output stream
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    // tdata: found_index[9:0], zero pad
    output logic      [icl_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    // tuser: found
    output logic                                  m_axis_tuser,
    // Register port
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [icl_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire logic [icl_pkg::APB_DATA_W-1:0]   pwdata,
    output logic      [icl_pkg::APB_DATA_W-1:0]   prdata,
    output logic                                  pready
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLAMP,
        S_B_RD,
        S_B_CMP,
        S_F_RD,
        S_F_CMP,
        S_CHK,
        S_DONE
    } t_state;

    localparam int TW = icl_pkg::TIME_W;
    localparam int IW = icl_pkg::IDX_W;
    localparam int CW = icl_pkg::CUR_W;
    localparam int NW = icl_pkg::CNT_W;

    t_state                  r_state, n_state;
    logic signed [CW-1:0]    r_cursor, n_cursor;
    logic [NW-1:0]           r_n, n_n;
    logic [TW-1:0]           r_time, n_time;
    logic                    r_hit, n_hit;
    logic                    r_out_valid, n_out_valid;
    logic                    r_found, n_found;
    logic [IW-1:0]           r_found_idx, n_found_idx;
    logic [NW-1:0]           r_entry_count;

    logic                    w_in_acc;
    logic                    w_out_acc;
    logic                    w_cfg_wr;
    logic                    w_ram_we;
    logic                    w_ram_re;
    logic [2*TW-1:0]         w_ram_wdata;
    logic [2*TW-1:0]         w_ram_rdata;
    logic [TW-1:0]           w_start;
    logic [TW-1:0]           w_stop;
    logic [TW-1:0]           w_operand;
    logic signed [CW-1:0]    w_n_s;
    logic signed [CW-1:0]    w_cur_inc;
    logic signed [CW-1:0]    w_cur_dec;
    icl_pkg::t_cmp_res       w_cmp;

    // Handshakes; hold the input off while in reset
    assign s_axis_tready = i_rst_n && (r_state == S_IDLE);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_out_acc     = r_out_valid && m_axis_tready;

    // Register port: always ready, one register at word index zero
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready &&
                      (paddr[2] == icl_pkg::REG_ENTRY_COUNT);
    assign prdata   = (paddr[2] == icl_pkg::REG_ENTRY_COUNT) ?
                      {{(icl_pkg::APB_DATA_W-NW){1'b0}}, r_entry_count} :
                      '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_count <= '0;
        end else if (w_cfg_wr) begin
            r_entry_count <= pwdata[NW-1:0];
        end
    end

    // Interval table: stop time in the upper half, start time in the lower
    assign w_ram_we    = w_in_acc && (s_axis_tuser == icl_pkg::CMD_LOAD);
    assign w_ram_wdata = {s_axis_tdata[105:58], s_axis_tdata[57:10]};
    assign w_ram_re    = (r_state == S_B_RD) || (r_state == S_F_RD);

    icl_ram #(
        .WIDTH (2*TW),
        .DEPTH (icl_pkg::MAX_ENTRIES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (s_axis_tdata[IW-1:0]),
        .i_wdata (w_ram_wdata),
        .i_re    (w_ram_re),
        .i_raddr (r_cursor[IW-1:0]),
        .o_rdata (w_ram_rdata)
    );

    assign w_start = w_ram_rdata[TW-1:0];
    assign w_stop  = w_ram_rdata[2*TW-1:TW];

    // Pick start or stop time for the shared comparator
    assign w_operand = (r_state == S_F_CMP) ? w_stop : w_start;

    icl_cmp u_cmp (
        .i_stored (w_operand),
        .i_query  (r_time),
        .o_res    (w_cmp)
    );

    assign w_n_s     = signed'({1'b0, r_n});
    assign w_cur_inc = r_cursor + CW'(1);
    assign w_cur_dec = r_cursor - CW'(1);

    // Sequencer: clamp, walk back, walk forward, check, deliver
    always_comb begin
        n_state     = r_state;
        n_cursor    = r_cursor;
        n_n         = r_n;
        n_time      = r_time;
        n_hit       = r_hit;
        n_out_valid = r_out_valid;
        n_found     = r_found;
        n_found_idx = r_found_idx;

        if (w_out_acc) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    if (s_axis_tuser == icl_pkg::CMD_LOAD) begin
                        n_cursor = '0;
                    end else begin
                        n_time  = s_axis_tdata[153:106];
                        n_n     = (r_entry_count > NW'(icl_pkg::MAX_ENTRIES)) ?
                                  NW'(icl_pkg::MAX_ENTRIES) : r_entry_count;
                        n_state = S_CLAMP;
                    end
                end
            end
            S_CLAMP: begin
                if (r_n == '0) begin
                    n_hit   = 1'b0;
                    n_state = S_DONE;
                end else begin
                    if (r_cursor[CW-1]) begin
                        n_cursor = '0;
                    end else if (r_cursor >= w_n_s) begin
                        n_cursor = w_n_s - CW'(1);
                    end
                    n_state = S_B_RD;
                end
            end
            S_B_RD: begin
                n_state = S_B_CMP;
            end
            S_B_CMP: begin
                if (w_cmp.gt) begin
                    // start later than time: step back
                    n_cursor = w_cur_dec;
                    if (r_cursor == '0) begin
                        n_hit   = 1'b0;
                        n_state = S_DONE;
                    end else begin
                        n_state = S_B_RD;
                    end
                end else begin
                    // entry already read; test its stop time next
                    n_state = S_F_CMP;
                end
            end
            S_F_RD: begin
                n_state = S_F_CMP;
            end
            S_F_CMP: begin
                if (w_cmp.lt) begin
                    // stop earlier than time: step forward
                    n_cursor = w_cur_inc;
                    if (w_cur_inc == w_n_s) begin
                        n_hit   = 1'b0;
                        n_state = S_DONE;
                    end else begin
                        n_state = S_F_RD;
                    end
                end else begin
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                n_hit   = !w_cmp.gt;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_found     = r_hit;
                    n_found_idx = r_hit ? r_cursor[IW-1:0] : '0;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cursor    <= '0;
            r_out_valid <= 1'b0;
            r_hit       <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cursor    <= n_cursor;
            r_out_valid <= n_out_valid;
            r_hit       <= n_hit;
        end
        r_n         <= n_n;
        r_time      <= n_time;
        r_found     <= n_found;
        r_found_idx <= n_found_idx;
    end

    // Output word
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_found;
    assign m_axis_tdata  = {{(icl_pkg::OUT_DATA_W-IW){1'b0}}, r_found_idx};

    // A hit names a slot inside the table in use
    a_hit_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> ({1'b0, r_found_idx} < r_n))
        else $error("found index outside the table");

    // A miss carries index zero
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (r_found_idx == '0))
        else $error("miss with nonzero index");

    // A load rewinds the cursor
    a_load_rewind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && (s_axis_tuser == icl_pkg::CMD_LOAD)) |=> (r_cursor == '0))
        else $error("cursor not rewound after load");

    // While walking the cursor stays between zero and the count minus one
    a_cursor_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_B_RD) || (r_state == S_F_RD) || (r_state == S_CHK)) |->
        (!r_cursor[CW-1] && (r_cursor < w_n_s)))
        else $error("cursor outside the table during a walk");

endmodule
`default_nettype wire

// ===== rtl/icl_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none
module icl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write one entry, read one entry into the output register
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

// ===== rtl/icl_cmp.sv =====
// Shared magnitude comparator: stored time against the query time.
`default_nettype none
module icl_cmp (
    input  wire logic [icl_pkg::TIME_W-1:0] i_stored,
    input  wire logic [icl_pkg::TIME_W-1:0] i_query,
    output icl_pkg::t_cmp_res               o_res
);

    // Unsigned compare from one subtraction and an equality test
    logic [icl_pkg::TIME_W:0] w_diff;
    logic                     w_eq;

    assign w_diff   = {1'b0, i_query} - {1'b0, i_stored};
    assign w_eq     = (i_stored == i_query);
    assign o_res.gt = w_diff[icl_pkg::TIME_W];
    assign o_res.lt = !w_diff[icl_pkg::TIME_W] && !w_eq;

endmodule
`default_nettype wire
